// ----- hdl/ppu_pkg.sv -----
// ----------------------------------------------------------------------------
// ppu_pkg - shared constants for the particle pool update core
// Pool geometry, fixed-point formats, reciprocal constants and saturation.
// ----------------------------------------------------------------------------
package ppu_pkg;

    // pool geometry
    localparam int POOL_SIZE = 32;
    localparam int SLOT_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int POOL_W    = 6;   // width of the pool_in_use register

    // field widths
    localparam int POS_W   = 24;    // Q15.8
    localparam int ALPHA_W = 18;    // Q1.16
    localparam int SHADE_W = 9;     // Q1.8
    localparam int DT_W    = 16;    // Q0.16
    localparam int DRAW_W  = 7;
    localparam int OSLOT_W = 5;

    // shared multiplier
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;

    // item kinds
    localparam logic KIND_SPAWN = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // fixed-point limits
    localparam logic signed [POS_W-1:0]   POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0]   POS_MIN = 24'sh800000;
    localparam logic signed [ALPHA_W-1:0] Q16_MIN = 18'sh20000;
    localparam logic signed [ALPHA_W-1:0] ONE_Q16 = 18'sh10000;

    // divide by 10: q = (n * RECIP10) >> 27, exact for n below 2^26
    localparam logic signed [MUL_W-1:0] RECIP10    = 25'sd13421773;
    localparam int                      RECIP10_SH = 27;
    localparam int                      QUO10_W    = 21;
    // divide by 100: q = (n * RECIP100) >> 22, exact for n below 43690
    localparam logic signed [MUL_W-1:0] RECIP100    = 25'sd41944;
    localparam int                      RECIP100_SH = 22;

    // rounding offsets and spawn constants
    localparam logic signed [7:0]       JIT_CENTRE = 8'sd50;
    localparam logic [15:0]             HALF_TEN   = 16'd5;
    localparam logic [15:0]             HALF_HUND  = 16'd50;
    localparam logic [SHADE_W-1:0]      SHADE_BASE = 9'd128;
    localparam int                      MOVE_SH    = 16;

    // saturate a position sum to signed Q15.8
    function automatic logic signed [POS_W-1:0] sat24(input logic signed [POS_W+1:0] v);
        logic signed [POS_W-1:0] res;
        if (v > (POS_W+2)'(POS_MAX)) begin
            res = POS_MAX;
        end else if (v < (POS_W+2)'(POS_MIN)) begin
            res = POS_MIN;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- hdl/particle_pool_update_core.sv -----
// ----------------------------------------------------------------------------
// particle_pool_update_core - fixed particle pool with spawn and tick requests
// Sequenced datapath around one shared 25x25 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; i_kind
//   selects spawn (0) or tick (1). busy drops in the cycle that carries the
//   request's last result, so the next request can be taken at the edge that
//   ends that cycle. Results appear on the o_ ports for one cycle, flagged by
//   o_valid; the receiver cannot stall them. o_last marks the final result.
//   Spawn: the dead-slot search checks one slot per cycle, at most pool_in_use
//   slots, then four multiplier passes for the divide-by-constant work and a
//   write state; the one result is strobed in the cycle after the write.
//   Tick: one result per slot in use in slot order; a dead slot is handled in
//   ST_TK_LIFE alone, a live slot in ST_TK_LIFE, ST_TK_MY and ST_TK_UPD (two
//   multiplier passes for velocity * dt).
//   pool_in_use is written through i_cfg_we / i_cfg_wdata; the user is to
//   write it only while idle, as the block itself does not enforce it.
//   Reset (synchronous, active low) clears every slot (all dead, zero state),
//   the search start and sets pool_in_use to 32.
// ----------------------------------------------------------------------------
module particle_pool_update_core import ppu_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [POOL_W-1:0]          i_cfg_wdata,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_kind,
    input  logic [DT_W-1:0]            i_step_time,
    input  logic signed [POS_W-1:0]    i_emitter_x,
    input  logic signed [POS_W-1:0]    i_emitter_y,
    input  logic signed [POS_W-1:0]    i_emitter_vx,
    input  logic signed [POS_W-1:0]    i_emitter_vy,
    input  logic signed [POS_W-1:0]    i_offset_x,
    input  logic signed [POS_W-1:0]    i_offset_y,
    input  logic [DRAW_W-1:0]          i_jitter_draw,
    input  logic [DRAW_W-1:0]          i_shade_draw,
    output logic                       o_valid,
    output logic [OSLOT_W-1:0]         o_slot,
    output logic                       o_alive,
    output logic signed [POS_W-1:0]    o_pos_x,
    output logic signed [POS_W-1:0]    o_pos_y,
    output logic [SHADE_W-1:0]         o_shade,
    output logic signed [ALPHA_W-1:0]  o_alpha,
    output logic                       o_last
);

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SEARCH   = 4'd1;
    localparam logic [3:0] ST_SP_JIT   = 4'd2;
    localparam logic [3:0] ST_SP_VX    = 4'd3;
    localparam logic [3:0] ST_SP_VY    = 4'd4;
    localparam logic [3:0] ST_SP_SHADE = 4'd5;
    localparam logic [3:0] ST_SP_WRITE = 4'd6;
    localparam logic [3:0] ST_TK_LIFE  = 4'd7;
    localparam logic [3:0] ST_TK_MY    = 4'd8;
    localparam logic [3:0] ST_TK_UPD   = 4'd9;

    // control
    logic [3:0]         r_state, n_state;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic [SLOT_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0]  r_search, n_search;
    logic [POOL_W-1:0]  r_pool;

    // captured request
    logic [DT_W-1:0]            r_dt;
    logic [ALPHA_W-1:0]         r_fade;
    logic signed [POS_W-1:0]    r_ex, r_ey, r_evx, r_evy, r_ox, r_oy;
    logic [DRAW_W-1:0]          r_jit_draw, r_shade_draw;

    // spawn intermediates
    logic signed [POS_W-1:0]    r_jit, r_vx_q, r_vy_q;

    // slot storage
    logic signed [POS_W-1:0]    r_pos_x [POOL_SIZE];
    logic signed [POS_W-1:0]    r_pos_y [POOL_SIZE];
    logic signed [POS_W-1:0]    r_vel_x [POOL_SIZE];
    logic signed [POS_W-1:0]    r_vel_y [POOL_SIZE];
    logic signed [ALPHA_W-1:0]  r_life  [POOL_SIZE];
    logic signed [ALPHA_W-1:0]  r_alpha [POOL_SIZE];
    logic [SHADE_W-1:0]         r_shade [POOL_SIZE];

    // shared multiplier
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   r_prod;

    // output registers
    logic                       r_out_valid;
    logic [OSLOT_W-1:0]         r_out_slot;
    logic                       r_out_alive;
    logic signed [POS_W-1:0]    r_out_pos_x, r_out_pos_y;
    logic [SHADE_W-1:0]         r_out_shade;
    logic signed [ALPHA_W-1:0]  r_out_alpha;
    logic                       r_out_last;

    // combinational
    logic                       accept;
    logic [POOL_W-1:0]          pool_n;
    logic [SLOT_W-1:0]          start_slot;
    logic                       last_slot, last_check;
    logic [DT_W+2:0]            fade5;
    logic signed [ALPHA_W-1:0]  life_cur, life_new, alpha_new;
    logic signed [ALPHA_W:0]    life_dif;
    logic signed [ALPHA_W+1:0]  alpha_dif;
    logic                       life_alive;
    logic signed [POS_W-1:0]    pos_old, pos_upd;
    logic signed [PROD_W-1:0]   pos_sum;
    logic signed [POS_W:0]      pos_d;
    logic signed [7:0]          jit_diff;
    logic [6:0]                 jit_mag;
    logic [15:0]                jit_n, shade_n;
    logic signed [POS_W-1:0]    vel_in;
    logic [POS_W-1:0]           vel_mag;
    logic [POS_W:0]             vel_n;
    logic [QUO10_W-1:0]         quo10;
    logic [POS_W-1:0]           quo_ext;
    logic                       quo_neg;
    logic signed [POS_W-1:0]    quo_signed;
    logic signed [POS_W-1:0]    sp_pos_x, sp_pos_y;
    logic [SHADE_W-1:0]         sp_shade;
    logic                       emit_valid, emit_alive, emit_last;
    logic signed [POS_W-1:0]    emit_pos_x, emit_pos_y;
    logic [SHADE_W-1:0]         emit_shade;
    logic signed [ALPHA_W-1:0]  emit_alpha;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // effective pool size and search start
    always_comb begin
        if (r_pool == '0) begin
            pool_n = POOL_W'(1);
        end else if (r_pool > POOL_W'(POOL_SIZE)) begin
            pool_n = POOL_W'(POOL_SIZE);
        end else begin
            pool_n = r_pool;
        end
    end
    assign start_slot = (POOL_W'(r_search) < pool_n) ? r_search : '0;
    assign last_slot  = (POOL_W'(r_idx) == pool_n - POOL_W'(1));
    assign last_check = (POOL_W'(r_cnt) == pool_n - POOL_W'(1));

    // 2.5 * dt, ties upward
    assign fade5 = (DT_W+3)'({i_step_time, 2'b00}) + (DT_W+3)'(i_step_time) + (DT_W+3)'(1);

    // life and alpha update, saturating low
    assign life_cur   = r_life[r_idx];
    assign life_dif   = (ALPHA_W+1)'(life_cur) - $signed({3'b000, r_dt});
    assign life_new   = (life_dif < (ALPHA_W+1)'(Q16_MIN)) ? Q16_MIN : life_dif[ALPHA_W-1:0];
    assign life_alive = (life_new > 18'sd0);
    assign alpha_dif  = (ALPHA_W+2)'(r_alpha[r_idx]) - $signed({2'b00, r_fade});
    assign alpha_new  = (alpha_dif < (ALPHA_W+2)'(Q16_MIN)) ? Q16_MIN
                                                            : alpha_dif[ALPHA_W-1:0];

    // position move: (vel * dt + 2^15) >>> 16
    assign pos_old = (r_state == ST_TK_MY) ? r_pos_x[r_idx] : r_pos_y[r_idx];
    assign pos_sum = r_prod + PROD_W'(1 << (MOVE_SH - 1));
    assign pos_d   = $signed(pos_sum[MOVE_SH +: POS_W+1]);
    assign pos_upd = sat24((POS_W+2)'(pos_old) - (POS_W+2)'(pos_d));

    // divide-by-constant operands: magnitude plus half divisor
    assign jit_diff = $signed({1'b0, r_jit_draw}) - JIT_CENTRE;
    assign jit_mag  = jit_diff[7] ? 7'(-jit_diff) : jit_diff[6:0];
    assign jit_n    = {1'b0, jit_mag, 8'b0} + HALF_TEN;
    assign vel_in   = (r_state == ST_SP_VY) ? r_evy : r_evx;
    assign vel_mag  = vel_in[POS_W-1] ? (POS_W'(0) - POS_W'(vel_in)) : POS_W'(vel_in);
    assign vel_n    = {1'b0, vel_mag} + (POS_W+1)'(HALF_TEN);
    assign shade_n  = {1'b0, r_shade_draw, 8'b0} + HALF_HUND;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_SP_JIT: begin
                mul_a = MUL_W'(jit_n);
                mul_b = RECIP10;
            end
            ST_SP_VX, ST_SP_VY: begin
                mul_a = vel_n;
                mul_b = RECIP10;
            end
            ST_SP_SHADE: begin
                mul_a = MUL_W'(shade_n);
                mul_b = RECIP100;
            end
            ST_TK_LIFE: begin
                mul_a = MUL_W'(r_vel_x[r_idx]);
                mul_b = $signed({{(MUL_W-DT_W){1'b0}}, r_dt});
            end
            ST_TK_MY: begin
                mul_a = MUL_W'(r_vel_y[r_idx]);
                mul_b = $signed({{(MUL_W-DT_W){1'b0}}, r_dt});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // quotient from the previous multiplier pass, sign restored
    always_comb begin
        case (r_state)
            ST_SP_VX:    quo_neg = jit_diff[7];
            ST_SP_VY:    quo_neg = r_evx[POS_W-1];
            ST_SP_SHADE: quo_neg = r_evy[POS_W-1];
            default:     quo_neg = 1'b0;
        endcase
    end
    assign quo10      = r_prod[RECIP10_SH +: QUO10_W];
    assign quo_ext    = POS_W'(quo10);
    assign quo_signed = quo_neg ? $signed(POS_W'(0) - quo_ext) : $signed(quo_ext);

    // spawn values
    assign sp_pos_x = sat24((POS_W+2)'(r_ex) + (POS_W+2)'(r_jit) + (POS_W+2)'(r_ox));
    assign sp_pos_y = sat24((POS_W+2)'(r_ey) + (POS_W+2)'(r_jit) + (POS_W+2)'(r_oy));
    assign sp_shade = SHADE_BASE + r_prod[RECIP100_SH +: SHADE_W];

    // sequencer and result selection
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_search   = r_search;
        emit_valid = 1'b0;
        emit_alive = 1'b0;
        emit_last  = 1'b0;
        emit_pos_x = r_pos_x[r_idx];
        emit_pos_y = r_pos_y[r_idx];
        emit_shade = r_shade[r_idx];
        emit_alpha = r_alpha[r_idx];
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (i_kind == KIND_TICK) begin
                        n_idx   = '0;
                        n_state = ST_TK_LIFE;
                    end else begin
                        n_idx   = start_slot;
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (life_cur <= 18'sd0) begin
                    n_search = r_idx;
                    n_state  = ST_SP_JIT;
                end else if (last_check) begin
                    // no dead slot: fall back to slot zero
                    n_idx    = '0;
                    n_search = '0;
                    n_state  = ST_SP_JIT;
                end else begin
                    n_cnt = r_cnt + SLOT_W'(1);
                    n_idx = last_slot ? '0 : r_idx + SLOT_W'(1);
                end
            end
            ST_SP_JIT:   n_state = ST_SP_VX;
            ST_SP_VX:    n_state = ST_SP_VY;
            ST_SP_VY:    n_state = ST_SP_SHADE;
            ST_SP_SHADE: n_state = ST_SP_WRITE;
            ST_SP_WRITE: begin
                emit_valid = 1'b1;
                emit_alive = 1'b1;
                emit_last  = 1'b1;
                emit_pos_x = sp_pos_x;
                emit_pos_y = sp_pos_y;
                emit_shade = sp_shade;
                emit_alpha = ONE_Q16;
                n_state    = ST_IDLE;
            end
            ST_TK_LIFE: begin
                if (life_alive) begin
                    n_state = ST_TK_MY;
                end else begin
                    emit_valid = 1'b1;
                    emit_last  = last_slot;
                    n_idx      = r_idx + SLOT_W'(1);
                    n_state    = last_slot ? ST_IDLE : ST_TK_LIFE;
                end
            end
            ST_TK_MY:    n_state = ST_TK_UPD;
            ST_TK_UPD: begin
                emit_valid = 1'b1;
                emit_alive = 1'b1;
                emit_last  = last_slot;
                emit_pos_y = pos_upd;
                emit_alpha = alpha_new;
                n_idx      = r_idx + SLOT_W'(1);
                n_state    = last_slot ? ST_IDLE : ST_TK_LIFE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_search    <= '0;
            r_pool      <= POOL_W'(POOL_SIZE);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_search    <= n_search;
            r_out_valid <= emit_valid;
            if (i_cfg_we) begin
                r_pool <= i_cfg_wdata;
            end
        end
    end

    // request capture, multiplier product, spawn intermediates, result payload
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (accept) begin
            r_dt         <= i_step_time;
            r_fade       <= fade5[ALPHA_W:1];
            r_ex         <= i_emitter_x;
            r_ey         <= i_emitter_y;
            r_evx        <= i_emitter_vx;
            r_evy        <= i_emitter_vy;
            r_ox         <= i_offset_x;
            r_oy         <= i_offset_y;
            r_jit_draw   <= i_jitter_draw;
            r_shade_draw <= i_shade_draw;
        end
        case (r_state)
            ST_SP_VX:    r_jit  <= quo_signed;
            ST_SP_VY:    r_vx_q <= quo_signed;
            ST_SP_SHADE: r_vy_q <= quo_signed;
            default: ;
        endcase
        if (emit_valid) begin
            r_out_slot  <= OSLOT_W'(r_idx);
            r_out_alive <= emit_alive;
            r_out_pos_x <= emit_pos_x;
            r_out_pos_y <= emit_pos_y;
            r_out_shade <= emit_shade;
            r_out_alpha <= emit_alpha;
            r_out_last  <= emit_last;
        end
    end

    // slot storage, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SIZE; i++) begin
                r_pos_x[i] <= '0;
                r_pos_y[i] <= '0;
                r_vel_x[i] <= '0;
                r_vel_y[i] <= '0;
                r_life[i]  <= '0;
                r_alpha[i] <= '0;
                r_shade[i] <= '0;
            end
        end else begin
            case (r_state)
                ST_SP_WRITE: begin
                    r_pos_x[r_idx] <= sp_pos_x;
                    r_pos_y[r_idx] <= sp_pos_y;
                    r_vel_x[r_idx] <= r_vx_q;
                    r_vel_y[r_idx] <= r_vy_q;
                    r_shade[r_idx] <= sp_shade;
                    r_alpha[r_idx] <= ONE_Q16;
                    r_life[r_idx]  <= ONE_Q16;
                end
                ST_TK_LIFE: r_life[r_idx] <= life_new;
                ST_TK_MY:   r_pos_x[r_idx] <= pos_upd;
                ST_TK_UPD: begin
                    r_pos_y[r_idx] <= pos_upd;
                    r_alpha[r_idx] <= alpha_new;
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_slot  = r_out_slot;
    assign o_alive = r_out_alive;
    assign o_pos_x = r_out_pos_x;
    assign o_pos_y = r_out_pos_y;
    assign o_shade = r_out_shade;
    assign o_alpha = r_out_alpha;
    assign o_last  = r_out_last;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - self-checking bench for particle_pool_update_core
// Spawn and tick requests are queued by an initial block and driven in bursts
// on the falling edge. A monitor on the rising edge predicts the slot updates
// of each accepted request and checks every strobed result against them.
// ----------------------------------------------------------------------------
module testbench;
    import ppu_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 120;  // a full tick at 32 slots plus margin

    typedef enum logic [1:0] {
        ENTRY_REQUEST,
        ENTRY_POOL_WRITE,
        ENTRY_DRAIN
    } t_entry_kind;

    typedef struct {
        t_entry_kind             what;
        logic                    kind;
        logic [DT_W-1:0]         step_time;
        logic signed [POS_W-1:0] emitter_x;
        logic signed [POS_W-1:0] emitter_y;
        logic signed [POS_W-1:0] emitter_vx;
        logic signed [POS_W-1:0] emitter_vy;
        logic signed [POS_W-1:0] offset_x;
        logic signed [POS_W-1:0] offset_y;
        logic [DRAW_W-1:0]       jitter_draw;
        logic [DRAW_W-1:0]       shade_draw;
        logic [POOL_W-1:0]       pool;
    } t_pending_entry;

    typedef struct {
        logic [OSLOT_W-1:0]        slot;
        logic                      alive;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic [SHADE_W-1:0]        shade;
        logic signed [ALPHA_W-1:0] alpha;
        logic                      last;
    } t_particle_result;

    // DUT connections; the driven inputs are known from time zero
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [POOL_W-1:0]         i_cfg_wdata   = '0;
    logic                      start         = 1'b0;
    logic                      busy;
    logic                      i_kind        = KIND_SPAWN;
    logic [DT_W-1:0]           i_step_time   = '0;
    logic signed [POS_W-1:0]   i_emitter_x   = '0;
    logic signed [POS_W-1:0]   i_emitter_y   = '0;
    logic signed [POS_W-1:0]   i_emitter_vx  = '0;
    logic signed [POS_W-1:0]   i_emitter_vy  = '0;
    logic signed [POS_W-1:0]   i_offset_x    = '0;
    logic signed [POS_W-1:0]   i_offset_y    = '0;
    logic [DRAW_W-1:0]         i_jitter_draw = '0;
    logic [DRAW_W-1:0]         i_shade_draw  = '0;
    logic                      o_valid;
    logic [OSLOT_W-1:0]        o_slot;
    logic                      o_alive;
    logic signed [POS_W-1:0]   o_pos_x;
    logic signed [POS_W-1:0]   o_pos_y;
    logic [SHADE_W-1:0]        o_shade;
    logic signed [ALPHA_W-1:0] o_alpha;
    logic                      o_last;

    // stimulus and scoreboard
    t_pending_entry   request_queue[$];
    t_particle_result results_due[$];
    int unsigned      n_issued     = 0;
    int unsigned      n_accepted   = 0;
    int unsigned      burst_left   = 8;
    int unsigned      gap_left     = 0;
    int unsigned      quiet_cycles = 0;
    int               error_count  = 0;
    bit               rst_done     = 1'b0;
    bit               timed_out    = 1'b0;

    // predicted pool contents
    logic signed [POS_W-1:0]   pos_x_q  [POOL_SIZE];
    logic signed [POS_W-1:0]   pos_y_q  [POOL_SIZE];
    logic signed [POS_W-1:0]   vel_x_q  [POOL_SIZE];
    logic signed [POS_W-1:0]   vel_y_q  [POOL_SIZE];
    logic signed [ALPHA_W-1:0] life_q   [POOL_SIZE];
    logic signed [ALPHA_W-1:0] alpha_q  [POOL_SIZE];
    logic [SHADE_W-1:0]        shade_q  [POOL_SIZE];
    int unsigned               search_from = 0;
    logic [POOL_W-1:0]         pool_reg    = 6'd32;

    particle_pool_update_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_step_time   (i_step_time),
        .i_emitter_x   (i_emitter_x),
        .i_emitter_y   (i_emitter_y),
        .i_emitter_vx  (i_emitter_vx),
        .i_emitter_vy  (i_emitter_vy),
        .i_offset_x    (i_offset_x),
        .i_offset_y    (i_offset_y),
        .i_jitter_draw (i_jitter_draw),
        .i_shade_draw  (i_shade_draw),
        .o_valid       (o_valid),
        .o_slot        (o_slot),
        .o_alive       (o_alive),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_shade       (o_shade),
        .o_alpha       (o_alpha),
        .o_last        (o_last)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor helpers
    // ------------------------------------------------------------------------

    // divide, rounding to nearest with ties away from zero
    function automatic longint round_div(longint n, longint d);
        if (n >= 0) begin
            return (n + d / 2) / d;
        end
        return -((-n + d / 2) / d);
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > longint'(POS_MAX)) begin
            return POS_MAX;
        end else if (v < longint'(POS_MIN)) begin
            return POS_MIN;
        end
        return POS_W'(v);
    endfunction

    // out-of-range register values fold onto 1 .. POOL_SIZE
    function automatic int unsigned active_slots();
        if (pool_reg < 1) begin
            return 1;
        end else if (pool_reg > POOL_SIZE) begin
            return POOL_SIZE;
        end
        return pool_reg;
    endfunction

    function automatic void queue_slot_result(int unsigned idx, logic is_last);
        t_particle_result res;
        res.slot  = OSLOT_W'(idx);
        res.alive = (life_q[idx] > 0);
        res.pos_x = pos_x_q[idx];
        res.pos_y = pos_y_q[idx];
        res.shade = shade_q[idx];
        res.alpha = alpha_q[idx];
        res.last  = is_last;
        results_due.insert(results_due.size(), res);
    endfunction

    // spawn: round-robin search for a dead slot, slot 0 when the pool is full
    function automatic void predict_spawn();
        int unsigned n;
        int unsigned first;
        int unsigned idx;
        bit          found;
        longint      jit;
        n     = active_slots();
        first = (search_from < n) ? search_from : 0;
        idx   = 0;
        found = 1'b0;
        for (int unsigned k = 0; k < n && !found; k++) begin
            int unsigned c;
            c = (first + k) % n;
            if (life_q[c] <= 0) begin
                idx   = c;
                found = 1'b1;
            end
        end
        search_from = idx;
        jit = round_div((longint'(i_jitter_draw) - 50) * 256, 10);
        pos_x_q[idx] = clamp_pos(longint'(i_emitter_x) + jit + longint'(i_offset_x));
        pos_y_q[idx] = clamp_pos(longint'(i_emitter_y) + jit + longint'(i_offset_y));
        vel_x_q[idx] = POS_W'(round_div(longint'(i_emitter_vx), 10));
        vel_y_q[idx] = POS_W'(round_div(longint'(i_emitter_vy), 10));
        shade_q[idx] = SHADE_W'(128 + (longint'(i_shade_draw) * 256 + 50) / 100);
        alpha_q[idx] = ONE_Q16;
        life_q[idx]  = ONE_Q16;
        queue_slot_result(idx, 1'b1);
    endfunction

    // tick: age every slot in use, move and fade the ones still alive
    function automatic void predict_tick();
        int unsigned n;
        longint      dt;
        longint      fade;
        longint      new_life;
        longint      new_alpha;
        longint      move;
        n    = active_slots();
        dt   = longint'(i_step_time);
        fade = (dt * 5 + 1) >>> 1;
        for (int unsigned i = 0; i < n; i++) begin
            new_life = longint'(life_q[i]) - dt;
            if (new_life < longint'(Q16_MIN)) begin
                new_life = longint'(Q16_MIN);
            end
            life_q[i] = ALPHA_W'(new_life);
            if (new_life > 0) begin
                // (v * dt) >> 16, rounded half up
                move = (longint'(vel_x_q[i]) * dt + 32768) >>> MOVE_SH;
                pos_x_q[i] = clamp_pos(longint'(pos_x_q[i]) - move);
                move = (longint'(vel_y_q[i]) * dt + 32768) >>> MOVE_SH;
                pos_y_q[i] = clamp_pos(longint'(pos_y_q[i]) - move);
                new_alpha = longint'(alpha_q[i]) - fade;
                if (new_alpha < longint'(Q16_MIN)) begin
                    new_alpha = longint'(Q16_MIN);
                end
                alpha_q[i] = ALPHA_W'(new_alpha);
            end
            queue_slot_result(i, (i + 1 == n));
        end
    endfunction

    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_pending_entry blank_entry(t_entry_kind what);
        t_pending_entry e;
        e.what        = what;
        e.kind        = KIND_SPAWN;
        e.step_time   = '0;
        e.emitter_x   = '0;
        e.emitter_y   = '0;
        e.emitter_vx  = '0;
        e.emitter_vy  = '0;
        e.offset_x    = '0;
        e.offset_y    = '0;
        e.jitter_draw = '0;
        e.shade_draw  = '0;
        e.pool        = '0;
        return e;
    endfunction

    function automatic void add_spawn(logic signed [POS_W-1:0] ex, logic signed [POS_W-1:0] ey,
                                      logic signed [POS_W-1:0] vx, logic signed [POS_W-1:0] vy,
                                      logic signed [POS_W-1:0] ox, logic signed [POS_W-1:0] oy,
                                      logic [DRAW_W-1:0] jit, logic [DRAW_W-1:0] shd);
        t_pending_entry e;
        e = blank_entry(ENTRY_REQUEST);
        e.kind        = KIND_SPAWN;
        e.emitter_x   = ex;
        e.emitter_y   = ey;
        e.emitter_vx  = vx;
        e.emitter_vy  = vy;
        e.offset_x    = ox;
        e.offset_y    = oy;
        e.jitter_draw = jit;
        e.shade_draw  = shd;
        e.step_time   = DT_W'($urandom);  // ignored by a spawn
        request_queue.insert(request_queue.size(), e);
    endfunction

    function automatic void add_tick(logic [DT_W-1:0] dt);
        t_pending_entry e;
        e = blank_entry(ENTRY_REQUEST);
        e.kind      = KIND_TICK;
        e.step_time = dt;
        request_queue.insert(request_queue.size(), e);
    endfunction

    function automatic void add_pool_write(logic [POOL_W-1:0] value);
        t_pending_entry e;
        e = blank_entry(ENTRY_POOL_WRITE);
        e.pool = value;
        request_queue.insert(request_queue.size(), e);
    endfunction

    function automatic void add_drain();
        request_queue.insert(request_queue.size(), blank_entry(ENTRY_DRAIN));
    endfunction

    // mostly near the origin, sometimes anywhere in Q15.8
    function automatic logic signed [POS_W-1:0] pick_coord();
        if ($urandom_range(0, 3) == 0) begin
            return POS_W'($urandom);
        end
        return POS_W'($urandom_range(0, 131071)) - 24'sd65536;
    endfunction

    function automatic logic [DRAW_W-1:0] pick_draw();
        if ($urandom_range(0, 4) == 0) begin
            return DRAW_W'($urandom_range(0, 127));
        end
        return DRAW_W'($urandom_range(0, 99));
    endfunction

    // short ticks keep particles alive over many requests
    function automatic logic [DT_W-1:0] pick_step();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return DT_W'($urandom);
            4, 5, 6: return DT_W'($urandom_range(3001, 20000));
            default: return DT_W'($urandom_range(0, 3000));
        endcase
    endfunction

    function automatic logic [POOL_W-1:0] pick_pool();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd63;
            3, 4:    return 6'd32;
            5:       return 6'd2;
            6, 7:    return POOL_W'($urandom_range(3, 8));
            default: return POOL_W'($urandom_range(1, 63));
        endcase
    endfunction

    function automatic int unsigned draw_gap();
        case ($urandom_range(0, 9))
            0, 1, 2:    return 0;
            3, 4, 5, 6: return $urandom_range(1, 4);
            7, 8:       return $urandom_range(5, 30);
            default:    return $urandom_range(31, 120);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driver: one request at a time, bursts separated by random gaps
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_requests
        logic           nxt_start;
        logic           nxt_we;
        t_pending_entry head;
        nxt_start = start;
        nxt_we    = 1'b0;
        if (rst_done) begin
            // request taken at the last rising edge
            if (start && n_accepted == n_issued) begin
                nxt_start = 1'b0;
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_queue.size() > 0) begin
                    head = request_queue[0];
                    case (head.what)
                        ENTRY_REQUEST: begin
                            i_kind        <= head.kind;
                            i_step_time   <= head.step_time;
                            i_emitter_x   <= head.emitter_x;
                            i_emitter_y   <= head.emitter_y;
                            i_emitter_vx  <= head.emitter_vx;
                            i_emitter_vy  <= head.emitter_vy;
                            i_offset_x    <= head.offset_x;
                            i_offset_y    <= head.offset_y;
                            i_jitter_draw <= head.jitter_draw;
                            i_shade_draw  <= head.shade_draw;
                            nxt_start = 1'b1;
                            n_issued++;
                            void'(request_queue.pop_front());
                            burst_left--;
                            if (burst_left == 0) begin
                                burst_left = $urandom_range(1, 24);
                                gap_left   = draw_gap();
                            end
                        end
                        ENTRY_POOL_WRITE: begin
                            // register only changes with the core idle
                            if (results_due.size() == 0 && !busy) begin
                                i_cfg_wdata <= head.pool;
                                nxt_we = 1'b1;
                                void'(request_queue.pop_front());
                            end
                        end
                        default: begin
                            if (results_due.size() == 0 && !busy) begin
                                void'(request_queue.pop_front());
                            end
                        end
                    endcase
                end
            end
        end
        start    <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // ------------------------------------------------------------------------
    // monitor: check results, predict accepted requests, watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_results
        t_particle_result due;
        bit               quiet;
        if (i_rst_n && rst_done) begin
            quiet = 1'b1;
            if (o_valid) begin
                quiet = 1'b0;
                if (results_due.size() == 0) begin
                    $error("result for slot %0d with nothing outstanding", o_slot);
                    error_count++;
                end else begin
                    due = results_due.pop_front();
                    check_field("slot",  due.slot,  o_slot);
                    check_field("alive", due.alive, o_alive);
                    check_field("pos_x", due.pos_x, o_pos_x);
                    check_field("pos_y", due.pos_y, o_pos_y);
                    check_field("shade", due.shade, o_shade);
                    check_field("alpha", due.alpha, o_alpha);
                    check_field("last",  due.last,  o_last);
                end
            end
            if (i_cfg_we) begin
                quiet    = 1'b0;
                pool_reg = i_cfg_wdata;
            end
            if (start && !busy) begin
                quiet = 1'b0;
                n_accepted++;
                if (i_kind == KIND_TICK) begin
                    predict_tick();
                end else begin
                    predict_spawn();
                end
            end
            if (quiet) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (quiet_cycles == WATCHDOG_LIMIT && !timed_out) begin
                $error("no progress for %0d cycles", WATCHDOG_LIMIT);
                error_count++;
                timed_out = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned spawn_pct;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pos_x_q[i] = '0;
            pos_y_q[i] = '0;
            vel_x_q[i] = '0;
            vel_y_q[i] = '0;
            life_q[i]  = '0;
            alpha_q[i] = '0;
            shade_q[i] = '0;
        end

        // directed: position extremes with velocities that push further out
        add_spawn(POS_MAX, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 7'd127, 7'd127);
        add_spawn(POS_MIN, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MAX, 7'd0, 7'd0);
        // velocity rounding ties either side of zero
        add_spawn(24'sd0, 24'sd0, 24'sd5, -24'sd5, 24'sd0, 24'sd0, 7'd50, 7'd99);
        add_spawn(24'sd256, -24'sd256, 24'sd15, -24'sd15, 24'sd1, -24'sd1, 7'd99, 7'd100);
        add_spawn(-24'sd1, 24'sd1, -24'sd25, 24'sd35, 24'sd0, 24'sd0, 7'd45, 7'd1);
        // ticks: zero, minimum, moves that saturate, then life down to its floor
        add_tick(16'd0);
        add_tick(16'd1);
        add_tick(16'd60000);
        add_tick(16'hFFFF);
        add_tick(16'hFFFF);
        add_tick(16'hFFFF);
        // walk the search start up the pool
        repeat (3) add_spawn(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                             pick_coord(), pick_coord(), pick_draw(), pick_draw());
        add_drain();
        // small pool: stale search start, then a full pool overwriting slot 0
        add_pool_write(6'd2);
        repeat (3) add_spawn(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                             pick_coord(), pick_coord(), pick_draw(), pick_draw());
        add_pool_write(6'd1);
        repeat (2) add_spawn(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                             pick_coord(), pick_coord(), pick_draw(), pick_draw());
        // zero acts as one slot, above the pool size acts as the full pool
        add_pool_write(6'd0);
        add_spawn(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), pick_draw(), pick_draw());
        add_tick(16'hFFFF);
        add_pool_write(6'd63);
        add_tick(16'd100);
        add_pool_write(6'd32);

        // random phases, each with its own pool size and spawn/tick mix
        for (int phase = 0; phase < 10; phase++) begin
            if (phase > 0) begin
                add_pool_write(pick_pool());
            end
            spawn_pct = $urandom_range(30, 75);
            for (int k = 0; k < 50; k++) begin
                if ($urandom_range(1, 100) <= spawn_pct) begin
                    add_spawn(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                              pick_coord(), pick_coord(), pick_draw(), pick_draw());
                end else begin
                    add_tick(pick_step());
                end
                if ($urandom_range(0, 39) == 0) begin
                    add_drain();
                end
            end
        end

        // reset
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // run until every request is taken and answered
        while (!timed_out && (request_queue.size() != 0 || n_issued != n_accepted ||
                              results_due.size() != 0)) begin
            @(posedge i_clk);
        end
        if (!timed_out) begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
        if (results_due.size() != 0) begin
            $error("%0d results still outstanding", results_due.size());
            error_count++;
        end

        if (!timed_out && error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ppu_pkg.sv
hdl/particle_pool_update_core.sv
tb/sv/testbench.sv
